### rtl/core/dfbt_pkg.sv
package dfbt_pkg;

    // Table geometry
    localparam int TableEntries = 16;
    localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;

    // Field widths
    localparam int OpW    = 2;
    localparam int AddrW  = 64;
    localparam int CountW = 8;
    localparam int TimeW  = 32;
    localparam int SecW   = 16;
    localparam int EvW    = 3;
    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 16;
    localparam int InDataW  = 136;
    localparam int OutDataW = 8;

    // Operation codes
    localparam logic [OpW-1:0] OpMessage = 2'd0;
    localparam logic [OpW-1:0] OpQuery   = 2'd1;
    localparam logic [OpW-1:0] OpTick    = 2'd2;

    // Register indexes
    localparam logic [CfgIdxW-1:0] CfgCountThreshold = 2'd0;
    localparam logic [CfgIdxW-1:0] CfgStrikeLimit    = 2'd1;
    localparam logic [CfgIdxW-1:0] CfgTempBlockSec   = 2'd2;
    localparam logic [CfgIdxW-1:0] CfgWindowSec      = 2'd3;

    // Register reset values
    localparam logic [CountW-1:0] RstCountThreshold = 8'd3;
    localparam logic [CountW-1:0] RstStrikeLimit    = 8'd2;
    localparam logic [SecW-1:0]   RstTempBlockSec   = 16'd60;
    localparam logic [SecW-1:0]   RstWindowSec      = 16'd300;

    // Result event codes
    typedef enum logic [EvW-1:0] {
        EvNone    = 3'd0,
        EvCounted = 3'd1,
        EvTemp    = 3'd2,
        EvPerm    = 3'd3,
        EvFull    = 3'd4,
        EvWindow  = 3'd5
    } ev_code_t;

    // Controller states
    typedef enum logic [1:0] {
        StIdle,
        StLookup,
        StResolve,
        StExec
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load;
        logic lookup;
        logic resolve;
        logic exec;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_stall;
    } sts_t;

endpackage

### rtl/core/dis_flood_blocklist_table.sv
// Per-source rate limiter and blocklist for DIS control messages. Each request
// carries an op (0 message, 1 blocked query, 2 one-second tick) and a 128-bit
// source address; every request yields exactly one result giving the blocked
// flag and an event code. A table of 16 sources is searched by comparing the
// address against all entries at once; a miss allocates the lowest free slot,
// and a full table reports "table full". A request passes through accept,
// compare, slot select and update, and the update waits while a result is
// still untaken; one request is in flight at a time, and the result register
// lets the next request be accepted while a result waits to be taken. The
// user must write registers through the cfg port only while no request is in
// flight, which the block does not enforce: 0 count threshold, 1 strike
// limit, 2 temporary block length in ticks, 3 window length in ticks.
module dis_flood_blocklist_table
    import dfbt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,   // op[1:0], addr_hi[65:2], addr_lo[129:66]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,   // blocked[0], event_res[3:1]
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata
);

    cmd_t cmd;
    sts_t sts;

    dfbt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dfbt_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

### rtl/core/dfbt_ctrl.sv
module dfbt_ctrl
    import dfbt_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   s_tvalid,
    output logic   s_tready,
    input  sts_t   sts,
    output cmd_t   cmd
);

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= StIdle;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            StIdle: begin
                if (s_tvalid) state_next = StLookup;
            end
            StLookup:  state_next = StResolve;
            StResolve: state_next = StExec;
            StExec: begin
                if (!sts.out_stall) state_next = StIdle;
            end
            default:   state_next = StIdle;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            StIdle: begin
                s_tready = 1'b1;
                cmd.load = s_tvalid;
            end
            StLookup:  cmd.lookup  = 1'b1;
            StResolve: cmd.resolve = 1'b1;
            StExec:    cmd.exec    = !sts.out_stall;
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/dfbt_datapath.sv
module dfbt_datapath
    import dfbt_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [InDataW-1:0]  s_tdata,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,
    input  logic                cfg_wr_en,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [CfgDataW-1:0] cfg_wdata,
    input  cmd_t                cmd,
    output sts_t                sts
);

    // Configuration
    logic [CountW-1:0] thr_reg;
    logic [CountW-1:0] limit_reg;
    logic [SecW-1:0]   temp_reg;
    logic [SecW-1:0]   window_reg;

    // Table
    logic              valid_reg [TableEntries];
    logic [AddrW-1:0]  key_hi_reg [TableEntries];
    logic [AddrW-1:0]  key_lo_reg [TableEntries];
    logic [CountW-1:0] cnt_reg [TableEntries];
    logic [CountW-1:0] str_reg [TableEntries];
    logic              perm_reg [TableEntries];
    logic [TimeW-1:0]  exp_reg [TableEntries];
    logic [TimeW-1:0]  now_reg;
    logic [SecW-1:0]   elapsed_reg;

    // Request in flight
    logic [OpW-1:0]          op_reg;
    logic [AddrW-1:0]        hi_reg;
    logic [AddrW-1:0]        lo_reg;
    logic [TableEntries-1:0] hit_vec_reg;
    logic [TableEntries-1:0] free_vec_reg;
    logic                    hit_reg;
    logic                    full_reg;
    logic [IdxW-1:0]         idx_reg;

    // Result
    logic     out_valid_reg;
    logic     blk_reg;
    ev_code_t ev_reg;

    // Priority encode of the lookup vectors
    logic [IdxW-1:0] hit_idx;
    logic [IdxW-1:0] free_idx;

    always_comb begin
        hit_idx  = '0;
        free_idx = '0;
        for (int i = TableEntries - 1; i >= 0; i--) begin
            if (hit_vec_reg[i])  hit_idx  = IdxW'(i);
            if (free_vec_reg[i]) free_idx = IdxW'(i);
        end
    end

    // Update of the selected entry
    logic [CountW-1:0] cur_cnt, cur_str, cnt_inc, str_inc;
    logic              cur_perm, blocked_now, over, go_perm, tracked;
    logic [TimeW-1:0]  cur_exp, exp_sat;
    logic [TimeW:0]    exp_sum;
    logic [CountW-1:0] cnt_next, str_next;
    logic              perm_next, blk_next, wr_entry;
    logic [TimeW-1:0]  exp_next, now_next;
    logic [SecW-1:0]   elapsed_inc, elapsed_next;
    logic              win_clear;
    ev_code_t          ev_next;

    always_comb begin
        cur_cnt  = hit_reg ? cnt_reg[idx_reg]  : '0;
        cur_str  = hit_reg ? str_reg[idx_reg]  : '0;
        cur_perm = hit_reg ? perm_reg[idx_reg] : 1'b0;
        cur_exp  = hit_reg ? exp_reg[idx_reg]  : '0;

        blocked_now = cur_perm || ((cur_exp != '0) && (now_reg < cur_exp));
        cnt_inc = (cur_cnt == '1) ? cur_cnt : cur_cnt + 1'b1;
        str_inc = (cur_str == '1) ? cur_str : cur_str + 1'b1;
        over    = cnt_inc > thr_reg;
        go_perm = str_inc >= limit_reg;
        exp_sum = {1'b0, now_reg} + {{(TimeW + 1 - SecW){1'b0}}, temp_reg};
        exp_sat = exp_sum[TimeW] ? '1 : exp_sum[TimeW-1:0];
        tracked = (op_reg == OpMessage) || (op_reg == OpQuery);

        cnt_next  = cur_cnt;
        str_next  = cur_str;
        perm_next = cur_perm;
        exp_next  = cur_exp;
        blk_next  = 1'b0;
        ev_next   = EvNone;
        wr_entry  = 1'b0;

        // Tick: saturating clocks and window
        now_next     = (now_reg == '1) ? now_reg : now_reg + 1'b1;
        elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 1'b1;
        win_clear    = 1'b0;
        elapsed_next = elapsed_reg;

        case (op_reg) inside
            OpMessage, OpQuery: begin
                if (full_reg) begin
                    ev_next = EvFull;
                end else begin
                    wr_entry = 1'b1;
                    if (op_reg == OpQuery) begin
                        blk_next = blocked_now;
                    end else if (blocked_now) begin
                        blk_next = 1'b1;
                    end else if (over) begin
                        cnt_next = '0;
                        str_next = str_inc;
                        if (go_perm) begin
                            perm_next = 1'b1;
                            blk_next  = 1'b1;
                            ev_next   = EvPerm;
                        end else begin
                            // expiry lies ahead of now unless zero length or clock at top
                            exp_next = exp_sat;
                            blk_next = (temp_reg != '0) && (now_reg != '1);
                            ev_next  = EvTemp;
                        end
                    end else begin
                        cnt_next = cnt_inc;
                        ev_next  = EvCounted;
                    end
                end
            end
            OpTick: begin
                elapsed_next = elapsed_inc;
                if (elapsed_inc >= window_reg) begin
                    win_clear    = 1'b1;
                    elapsed_next = '0;
                    ev_next      = EvWindow;
                end
            end
            default: begin
                ev_next = EvNone;
            end
        endcase
    end

    assign sts.out_stall = out_valid_reg && !m_tready;

    // Control and state with reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg       <= RstCountThreshold;
            limit_reg     <= RstStrikeLimit;
            temp_reg      <= RstTempBlockSec;
            window_reg    <= RstWindowSec;
            now_reg       <= '0;
            elapsed_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TableEntries; i++) begin
                valid_reg[i] <= 1'b0;
                cnt_reg[i]   <= '0;
                str_reg[i]   <= '0;
                perm_reg[i]  <= 1'b0;
                exp_reg[i]   <= '0;
            end
        end else begin
            // Register writes
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CfgCountThreshold: thr_reg    <= cfg_wdata[CountW-1:0];
                    CfgStrikeLimit:    limit_reg  <= cfg_wdata[CountW-1:0];
                    CfgTempBlockSec:   temp_reg   <= cfg_wdata;
                    CfgWindowSec:      window_reg <= cfg_wdata;
                    default:           thr_reg    <= thr_reg;
                endcase
            end

            if (cmd.exec) begin
                out_valid_reg <= 1'b1;
                if (op_reg == OpTick) begin
                    now_reg     <= now_next;
                    elapsed_reg <= elapsed_next;
                end
                // Window clears every count
                if (win_clear) begin
                    for (int i = 0; i < TableEntries; i++) begin
                        cnt_reg[i] <= '0;
                    end
                end
                if (wr_entry && tracked) begin
                    valid_reg[idx_reg] <= 1'b1;
                    cnt_reg[idx_reg]   <= cnt_next;
                    str_reg[idx_reg]   <= str_next;
                    perm_reg[idx_reg]  <= perm_next;
                    exp_reg[idx_reg]   <= exp_next;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg <= s_tdata[1:0];
            hi_reg <= s_tdata[65:2];
            lo_reg <= s_tdata[129:66];
        end
        // Compare the key against every entry
        if (cmd.lookup) begin
            for (int i = 0; i < TableEntries; i++) begin
                hit_vec_reg[i]  <= valid_reg[i] && (key_hi_reg[i] == hi_reg)
                                   && (key_lo_reg[i] == lo_reg);
                free_vec_reg[i] <= !valid_reg[i];
            end
        end
        if (cmd.resolve) begin
            hit_reg  <= |hit_vec_reg;
            full_reg <= !(|hit_vec_reg) && !(|free_vec_reg);
            idx_reg  <= (|hit_vec_reg) ? hit_idx : free_idx;
        end
        if (cmd.exec) begin
            blk_reg <= blk_next;
            ev_reg  <= ev_next;
            if (wr_entry && !hit_reg) begin
                key_hi_reg[idx_reg] <= hi_reg;
                key_lo_reg[idx_reg] <= lo_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OutDataW - EvW - 1){1'b0}}, ev_reg, blk_reg};

endmodule

### rtl/core/dfbt_checker.sv
module dfbt_checker
    import dfbt_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata
);

    // A waiting result holds still
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // One request in flight at a time
    a_one_inflight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while another in flight");

    // A fresh result follows a request by the update latency
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4))
        else $error("result without matching request");

    // Blocked is only reported with no event, a temporary or a permanent block
    a_blk_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> (m_tdata[3:1] == EvNone) || (m_tdata[3:1] == EvTemp)
                                   || (m_tdata[3:1] == EvPerm))
        else $error("blocked with unexpected event");

endmodule

bind dis_flood_blocklist_table dfbt_checker u_chk (.*);
